/* hdl/akf_pkg.sv */
// ----------------------------------------------------------------------------
// akf_pkg
// shared types and constants for the angle kalman filter
// ----------------------------------------------------------------------------
`default_nettype none
package akf_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned CsrIdxWidth = 2;
   localparam logic [30:0] AngleNoiseReset = 31'd16777;
   localparam logic [30:0] BiasNoiseReset = 31'd50332;
   localparam logic [30:0] MeasureNoiseReset = 31'd503316;
   localparam logic [31:0] StepTimeReset = 32'd2684355;

   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [1:0] CSR_STEP_TIME = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RATE, ST_M_ANG, ST_ANG, ST_M_T1, ST_INNER, ST_M_PAA, ST_PAA,
      ST_PAB, ST_PBA, ST_M_PBB, ST_PBB, ST_DIV0, ST_K0, ST_DIV1, ST_K1, ST_Y,
      ST_M_C0, ST_C0, ST_M_C1, ST_C1, ST_M_C2, ST_C2, ST_M_C3, ST_C3,
      ST_M_C4, ST_C4, ST_M_C5, ST_C5, ST_OUT
   } state_type;

   // signed saturation of a wide value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

/* hdl/akf_if.sv */
// ----------------------------------------------------------------------------
// akf_req_if / akf_rsp_if
// valid/ready channels of the filter
// ----------------------------------------------------------------------------
`default_nettype none
interface akf_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] measured_angle;
   logic signed [31:0] measured_rate;
   logic force_angle;
   modport source(output valid, measured_angle, measured_rate, force_angle,
                  input ready);
   modport sink(input valid, measured_angle, measured_rate, force_angle,
                output ready);
endinterface

interface akf_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] filtered_angle;
   logic signed [31:0] bias_estimate;
   modport source(output valid, filtered_angle, bias_estimate, input ready);
   modport sink(input valid, filtered_angle, bias_estimate, output ready);
endinterface
`default_nettype wire

/* hdl/akf_serial_mul.sv */
// ----------------------------------------------------------------------------
// akf_serial_mul
// bit-serial signed multiply, 33 x 33 bits, one bit per cycle, rounded shift
// ----------------------------------------------------------------------------
`default_nettype none
module akf_serial_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [32:0] a,
   input  wire logic signed [32:0] b,
   input  wire logic               shift24,
   output logic                    done,
   output logic signed [65:0]      result
);
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] mcand_ff, mcand_in;
   logic [32:0] mplier_ff, mplier_in;
   logic [5:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic sh24_ff, sh24_in;
   logic signed [65:0] rnd;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh24_in = sh24_ff;
      if (start) begin
         acc_in = '0;
         mcand_in = 66'(a);
         mplier_in = b;
         count_in = '0;
         busy_in = 1'b1;
         sh24_in = shift24;
      end else if (busy_ff) begin
         // top multiplier bit carries negative weight
         if (mplier_ff[0]) begin
            if (count_ff == 6'd32) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      sh24_ff <= sh24_in;
   end

   always_comb begin
      if (sh24_ff) rnd = (acc_ff + 66'sd8388608) >>> 24;
      else rnd = (acc_ff + 66'sd2147483648) >>> 32;
   end
   assign done = done_ff;
   assign result = rnd;
endmodule
`default_nettype wire

/* hdl/akf_serial_div.sv */
// ----------------------------------------------------------------------------
// akf_serial_div
// restoring divide, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module akf_serial_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [32:0] den,
   output logic                    done,
   output logic signed [31:0]      gain
);
   // |num|*2^24 fits in 56 bits
   logic [55:0] quo_ff, quo_in;
   logic [56:0] rem_ff, rem_in;
   logic [32:0] dmag_ff, dmag_in;
   logic neg_ff, neg_in, zero_ff, zero_in;
   logic [5:0] count_ff, count_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [56:0] trial;
   logic [31:0] nmag;
   logic [56:0] qsat;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dmag_in = dmag_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nmag = num[31] ? 32'(-num) : 32'(num);
      trial = {rem_ff[55:0], quo_ff[55]} - {24'd0, dmag_ff};
      if (start) begin
         quo_in = {nmag, 24'd0};
         rem_in = '0;
         dmag_in = den[32] ? 33'(-den) : 33'(den);
         neg_in = num[31] ^ den[32];
         zero_in = (den == 33'sd0);
         count_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[56]) begin
            rem_in = trial;
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = {rem_ff[55:0], quo_ff[55]};
            quo_in = {quo_ff[54:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd55) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      qsat = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
      if (zero_ff) gain = '0;
      else gain = akf_pkg::sat32(66'(signed'(qsat)));
   end
   assign done = done_ff;
endmodule
`default_nettype wire

/* hdl/angle_kalman_filter.sv */
// ----------------------------------------------------------------------------
// angle_kalman_filter
// two-state angle/bias kalman filter, fixed point, bit-serial arithmetic
// ----------------------------------------------------------------------------
// One request beat gives one response beat. A force beat goes straight to
// ST_OUT, which sets the registered response valid; a filter beat first runs
// ten bit-serial multiplies, two restoring divides and five further steps,
// all run one after another on a single multiplier and a single divider. The
// request side is closed while an item is in work or its response waits, so
// the next beat is taken at the earliest in the cycle after the response beat.
`default_nettype none
module angle_kalman_filter (
   input  wire logic       clock,
   input  wire logic       reset,
   akf_req_if.sink         req,
   akf_rsp_if.source       rsp,
   input  wire logic       csr_write,
   input  wire logic [akf_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   typedef logic signed [31:0] w_type;
   akf_pkg::state_type state_ff, state_in;
   logic [30:0] qa_ff, qb_ff, r_ff;
   logic [31:0] dt_ff;
   w_type ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff;
   w_type z_ff, w_ff, t_ff, k0_ff, k1_ff, y_ff, p00_ff, p01_ff;
   w_type ang_in, bias_in, paa_in, pab_in, pba_in, pbb_in;
   w_type z_in, w_in, t_in, k0_in, k1_in, y_in, p00_in, p01_in;
   logic rv_ff, rv_in;
   logic mstart, m24, mdone, dstart, ddone;
   logic signed [32:0] ma, mb, dden;
   logic signed [65:0] mres;
   w_type dnum, dgain;

   akf_serial_mul u_mul (.clock, .reset, .start(mstart), .a(ma), .b(mb),
      .shift24(m24), .done(mdone), .result(mres));
   akf_serial_div u_div (.clock, .reset, .start(dstart), .num(dnum),
      .den(dden), .done(ddone), .gain(dgain));

   function automatic logic signed [65:0] x(input w_type v);
      return 66'(v);
   endfunction

   always_comb begin
      state_in = state_ff;
      {ang_in, bias_in, paa_in, pab_in, pba_in, pbb_in} =
         {ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff};
      {z_in, w_in, t_in, k0_in, k1_in, y_in, p00_in, p01_in} =
         {z_ff, w_ff, t_ff, k0_ff, k1_ff, y_ff, p00_ff, p01_ff};
      rv_in = rv_ff;
      mstart = 1'b0;
      m24 = 1'b0;
      ma = '0;
      mb = '0;
      dstart = 1'b0;
      dnum = paa_ff;
      dden = 33'(paa_ff) + 33'(signed'({2'b0, r_ff}));
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         akf_pkg::ST_IDLE: begin
            if (req.valid && !rv_ff) begin
               z_in = req.measured_angle;
               w_in = req.measured_rate;
               if (req.force_angle) begin
                  ang_in = req.measured_angle;
                  state_in = akf_pkg::ST_OUT;
               end else state_in = akf_pkg::ST_RATE;
            end
         end
         akf_pkg::ST_RATE: begin
            t_in = akf_pkg::sat32(x(w_ff) - x(bias_ff));
            state_in = akf_pkg::ST_M_ANG;
         end
         akf_pkg::ST_M_ANG: begin
            mstart = 1'b1; ma = 33'({1'b0, dt_ff}); mb = 33'(t_ff);
            state_in = akf_pkg::ST_ANG;
         end
         akf_pkg::ST_ANG: if (mdone) begin
            ang_in = akf_pkg::sat32(x(ang_ff) + mres);
            state_in = akf_pkg::ST_M_T1;
         end
         akf_pkg::ST_M_T1: begin
            mstart = 1'b1; ma = 33'({1'b0, dt_ff}); mb = 33'(pbb_ff);
            state_in = akf_pkg::ST_INNER;
         end
         akf_pkg::ST_INNER: if (mdone) begin
            t_in = mres[31:0]; // |dt*pbb| < 2^31
            y_in = akf_pkg::sat32(mres - x(pab_ff) - x(pba_ff) +
                                  66'(signed'({1'b0, qa_ff})));
            state_in = akf_pkg::ST_M_PAA;
         end
         akf_pkg::ST_M_PAA: begin
            mstart = 1'b1; ma = 33'({1'b0, dt_ff}); mb = 33'(y_ff);
            state_in = akf_pkg::ST_PAA;
         end
         akf_pkg::ST_PAA: if (mdone) begin
            paa_in = akf_pkg::sat32(x(paa_ff) + mres);
            state_in = akf_pkg::ST_PAB;
         end
         akf_pkg::ST_PAB: begin
            pab_in = akf_pkg::sat32(x(pab_ff) - x(t_ff));
            state_in = akf_pkg::ST_PBA;
         end
         akf_pkg::ST_PBA: begin
            pba_in = akf_pkg::sat32(x(pba_ff) - x(t_ff));
            state_in = akf_pkg::ST_M_PBB;
         end
         akf_pkg::ST_M_PBB: begin
            mstart = 1'b1; ma = 33'({2'b0, qb_ff}); mb = 33'({1'b0, dt_ff});
            state_in = akf_pkg::ST_PBB;
         end
         akf_pkg::ST_PBB: if (mdone) begin
            pbb_in = akf_pkg::sat32(x(pbb_ff) + mres);
            state_in = akf_pkg::ST_DIV0;
         end
         akf_pkg::ST_DIV0: begin
            dstart = 1'b1; dnum = paa_ff;
            state_in = akf_pkg::ST_K0;
         end
         akf_pkg::ST_K0: if (ddone) begin
            k0_in = dgain;
            state_in = akf_pkg::ST_DIV1;
         end
         akf_pkg::ST_DIV1: begin
            dstart = 1'b1; dnum = pba_ff;
            state_in = akf_pkg::ST_K1;
         end
         akf_pkg::ST_K1: if (ddone) begin
            k1_in = dgain;
            state_in = akf_pkg::ST_Y;
         end
         akf_pkg::ST_Y: begin
            y_in = akf_pkg::sat32(x(z_ff) - x(ang_ff));
            p00_in = paa_ff;
            p01_in = pab_ff;
            state_in = akf_pkg::ST_M_C0;
         end
         akf_pkg::ST_M_C0: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k0_ff); mb = 33'(y_ff);
            state_in = akf_pkg::ST_C0;
         end
         akf_pkg::ST_C0: if (mdone) begin
            ang_in = akf_pkg::sat32(x(ang_ff) + mres);
            state_in = akf_pkg::ST_M_C1;
         end
         akf_pkg::ST_M_C1: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k1_ff); mb = 33'(y_ff);
            state_in = akf_pkg::ST_C1;
         end
         akf_pkg::ST_C1: if (mdone) begin
            bias_in = akf_pkg::sat32(x(bias_ff) + mres);
            state_in = akf_pkg::ST_M_C2;
         end
         akf_pkg::ST_M_C2: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k0_ff); mb = 33'(p00_ff);
            state_in = akf_pkg::ST_C2;
         end
         akf_pkg::ST_C2: if (mdone) begin
            paa_in = akf_pkg::sat32(x(paa_ff) - mres);
            state_in = akf_pkg::ST_M_C3;
         end
         akf_pkg::ST_M_C3: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k0_ff); mb = 33'(p01_ff);
            state_in = akf_pkg::ST_C3;
         end
         akf_pkg::ST_C3: if (mdone) begin
            pab_in = akf_pkg::sat32(x(pab_ff) - mres);
            state_in = akf_pkg::ST_M_C4;
         end
         akf_pkg::ST_M_C4: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k1_ff); mb = 33'(p00_ff);
            state_in = akf_pkg::ST_C4;
         end
         akf_pkg::ST_C4: if (mdone) begin
            pba_in = akf_pkg::sat32(x(pba_ff) - mres);
            state_in = akf_pkg::ST_M_C5;
         end
         akf_pkg::ST_M_C5: begin
            mstart = 1'b1; m24 = 1'b1; ma = 33'(k1_ff); mb = 33'(p01_ff);
            state_in = akf_pkg::ST_C5;
         end
         akf_pkg::ST_C5: if (mdone) begin
            pbb_in = akf_pkg::sat32(x(pbb_ff) - mres);
            state_in = akf_pkg::ST_OUT;
         end
         akf_pkg::ST_OUT: begin
            rv_in = 1'b1;
            state_in = akf_pkg::ST_IDLE;
         end
         default: state_in = akf_pkg::ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == akf_pkg::ST_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.filtered_angle = ang_ff;
   assign rsp.bias_estimate = bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= akf_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         qa_ff <= akf_pkg::AngleNoiseReset;
         qb_ff <= akf_pkg::BiasNoiseReset;
         r_ff <= akf_pkg::MeasureNoiseReset;
         dt_ff <= akf_pkg::StepTimeReset;
         {ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff} <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         {ang_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff} <=
            {ang_in, bias_in, paa_in, pab_in, pba_in, pbb_in};
         if (csr_write) begin
            case (csr_index)
               akf_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_data[30:0];
               akf_pkg::CSR_BIAS_NOISE: qb_ff <= csr_data[30:0];
               akf_pkg::CSR_MEASURE_NOISE: r_ff <= csr_data[30:0];
               akf_pkg::CSR_STEP_TIME: dt_ff <= csr_data;
               default: ;
            endcase
         end
      end
      {z_ff, w_ff, t_ff, k0_ff, k1_ff, y_ff, p00_ff, p01_ff} <=
         {z_in, w_in, t_in, k0_in, k1_in, y_in, p00_in, p01_in};
   end
endmodule
`default_nettype wire

/* tb/tb_akf_scoreboard.sv */
// ----------------------------------------------------------------------------
// tb_akf_scoreboard
// predicts filtered angle and bias for each accepted beat and checks responses
// ----------------------------------------------------------------------------
package tb_akf_sb_pkg;
class akf_scoreboard;
   // configuration copy
   longint noise_angle, noise_bias, noise_meas, dt_step;
   // filter state copy
   longint ang, bias, paa, pab, pba, pbb;
   logic signed [31:0] want_angle[$];
   logic signed [31:0] want_bias[$];
   int errors;

   function new();
      noise_angle = 16777;
      noise_bias  = 50332;
      noise_meas  = 503316;
      dt_step     = 2684355;
      ang = 0; bias = 0; paa = 0; pab = 0; pba = 0; pbb = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
         akf_pkg::CSR_ANGLE_NOISE:   noise_angle = longint'(value[30:0]);
         akf_pkg::CSR_BIAS_NOISE:    noise_bias  = longint'(value[30:0]);
         akf_pkg::CSR_MEASURE_NOISE: noise_meas  = longint'(value[30:0]);
         akf_pkg::CSR_STEP_TIME:     dt_step     = longint'({32'd0, value});
         default: ;
      endcase
   endfunction

   static function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // exact product, round half up, arithmetic shift
   static function longint prod_round(longint a, longint b, int sh);
      logic signed [127:0] p;
      p = 128'(signed'(a)) * 128'(signed'(b));
      p = p + (128'sd1 <<< (sh - 1));
      p = p >>> sh;
      return longint'(p);
   endfunction

   static function longint gain_of(longint num, longint den);
      logic signed [127:0] q;
      if (den == 0) return 0;
      q = (128'(signed'(num)) <<< 24) / 128'(signed'(den));
      if (q > 128'sd2147483647) return 64'sd2147483647;
      if (q < -128'sd2147483648) return -64'sd2147483648;
      return longint'(q);
   endfunction

   function void note_beat(logic signed [31:0] z32, logic signed [31:0] w32, logic frc);
      longint z, w, rate, t1, inner, s, k0, k1, y, p00, p01;
      z = longint'(z32);
      w = longint'(w32);
      if (frc) begin
         ang = z;
      end else begin
         rate  = clamp(w - bias);
         ang   = clamp(ang + prod_round(dt_step, rate, 32));
         t1    = prod_round(dt_step, pbb, 32);
         inner = clamp(t1 - pab - pba + noise_angle);
         paa   = clamp(paa + prod_round(dt_step, inner, 32));
         pab   = clamp(pab - t1);
         pba   = clamp(pba - t1);
         pbb   = clamp(pbb + prod_round(noise_bias, dt_step, 32));
         s  = paa + noise_meas;
         k0 = gain_of(paa, s);
         k1 = gain_of(pba, s);
         y    = clamp(z - ang);
         ang  = clamp(ang + prod_round(k0, y, 24));
         bias = clamp(bias + prod_round(k1, y, 24));
         p00 = paa;
         p01 = pab;
         paa = clamp(paa - prod_round(k0, p00, 24));
         pab = clamp(pab - prod_round(k0, p01, 24));
         pba = clamp(pba - prod_round(k1, p00, 24));
         pbb = clamp(pbb - prod_round(k1, p01, 24));
      end
      want_angle.push_back(ang[31:0]);
      want_bias.push_back(bias[31:0]);
   endfunction

   function void check_beat(logic signed [31:0] got_angle, logic signed [31:0] got_bias);
      logic signed [31:0] ea, eb;
      if (want_angle.size() == 0) begin
         $display("%0t: unexpected response angle=%0d bias=%0d", $time, got_angle, got_bias);
         errors++;
         return;
      end
      ea = want_angle.pop_front();
      eb = want_bias.pop_front();
      if (got_angle !== ea) begin
         $display("%0t: filtered_angle expected %0d actual %0d", $time, ea, got_angle);
         errors++;
      end
      if (got_bias !== eb) begin
         $display("%0t: bias_estimate expected %0d actual %0d", $time, eb, got_bias);
         errors++;
      end
   endfunction

   function int pending();
      return want_angle.size();
   endfunction
endclass
endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the angle kalman filter against a predictor
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [akf_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   bit finished = 1'b0;

   akf_req_if req();
   akf_rsp_if rsp();
   tb_akf_sb_pkg::akf_scoreboard sb = new();

   angle_kalman_filter dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.measured_angle = '0;
      req.measured_rate = '0;
      req.force_angle = 1'b0;
      rsp.ready = 1'b0;
   end

   // response side: random stall, check each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) sb.check_beat(rsp.filtered_angle, rsp.bias_estimate);
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit && !finished) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_beat(logic signed [31:0] z, logic signed [31:0] w, logic frc);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req.valid <= 1'b1;
      req.measured_angle <= z;
      req.measured_rate <= w;
      req.force_angle <= frc;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_beat(z, w, frc);
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beats(int n);
      logic signed [31:0] z, w;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: z = $urandom;
            default: z = $signed($urandom_range(180 * 65536)) - 90 * 65536;
         endcase
         case ($urandom_range(3))
            0: w = $urandom;
            default: w = $signed($urandom_range(1000 * 65536)) - 500 * 65536;
         endcase
         send_beat(z, w, ($urandom_range(9) == 0));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes and force beats
      send_beat(32'sd0, 32'sd0, 1'b0);
      send_beat(32'sh7fffffff, 32'sh7fffffff, 1'b0);
      send_beat(32'sh80000000, 32'sh80000000, 1'b0);
      send_beat(32'sh7fffffff, 32'sh80000000, 1'b1);
      send_beat(32'sh80000000, 32'sh7fffffff, 1'b0);
      send_beat(32'sh80000000, 32'sd0, 1'b1);
      send_beat(32'sh7fffffff, 32'sh80000000, 1'b0);
      send_beat(32'sd65536 * 45, 32'sd65536, 1'b0);
      send_beat(-32'sd65536 * 89, -32'sd65536, 1'b0);
      drain();

      // zero noises and step: with zero measure noise the divisor is paa alone
      write_csr(akf_pkg::CSR_ANGLE_NOISE, 32'd0);
      write_csr(akf_pkg::CSR_BIAS_NOISE, 32'd0);
      write_csr(akf_pkg::CSR_MEASURE_NOISE, 32'd0);
      write_csr(akf_pkg::CSR_STEP_TIME, 32'd0);
      send_beat(32'sd12345, 32'sd777, 1'b0);
      send_beat(-32'sd12345, 32'sd777, 1'b0);
      drain();

      // largest noises and step
      write_csr(akf_pkg::CSR_ANGLE_NOISE, 32'hffffffff);
      write_csr(akf_pkg::CSR_BIAS_NOISE, 32'h7fffffff);
      write_csr(akf_pkg::CSR_MEASURE_NOISE, 32'h7fffffff);
      write_csr(akf_pkg::CSR_STEP_TIME, 32'hffffffff);
      send_beat(32'sh7fffffff, 32'sh80000000, 1'b0);
      send_beat(32'sh80000000, 32'sh7fffffff, 1'b0);
      send_beat(32'sd0, 32'sd0, 1'b0);
      drain();

      // random phases with different idle patterns and settings
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         write_csr(akf_pkg::CSR_ANGLE_NOISE, (ph == 0) ? 32'd16777 : $urandom);
         write_csr(akf_pkg::CSR_BIAS_NOISE,
                   (ph == 0) ? 32'd50332 : $urandom_range(200000));
         write_csr(akf_pkg::CSR_MEASURE_NOISE,
                   (ph == 3) ? $urandom : $urandom_range(2000000));
         write_csr(akf_pkg::CSR_STEP_TIME,
                   (ph == 2) ? $urandom : $urandom_range(10000000));
         random_beats(50);
         // let everything settle before the next beat
         drain();
         random_beats(50);
         drain();
      end

      finished = 1'b1;
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* angle_kalman_filter.f */
hdl/akf_pkg.sv
hdl/akf_if.sv
hdl/akf_serial_mul.sv
hdl/akf_serial_div.sv
hdl/angle_kalman_filter.sv
tb/tb_akf_scoreboard.sv
tb/tb_top.sv
